@@ src/assert_macros.svh @@
// Assertion macros used by gf2_poly_inverse.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent implies consequent a fixed number of cycles later.
`define ASSERT_DELAY(lbl, clk_s, rstn_s, ante, n, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> ##n (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons)
`define ASSERT_DELAY(lbl, clk_s, rstn_s, ante, n, cons)
`endif
`endif

@@ src/gpi_pkg.sv @@
// ---------------------------------------------------------------------------
// gpi_pkg
// Shared types for the GF(2) polynomial inverse pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package gpi_pkg;

    // Control that travels with each item through the pipeline.
    typedef struct packed {
        logic valid;
        logic fail;
    } stage_ctl_t;

endpackage
`default_nettype wire

@@ src/gpi_step.sv @@
// ---------------------------------------------------------------------------
// gpi_step
// One registered Euclid reduction step: the pair is ordered by degree and the
// lower one, shifted to align leading terms, is XORed into the higher one.
// The Bezout coefficients follow the same operation.
// ---------------------------------------------------------------------------
`default_nettype none
module gpi_step
    import gpi_pkg::*;
#(
    parameter int W = 9
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  stage_ctl_t        ctl_in,
    input  wire logic [W-1:0] a_in,
    input  wire logic [W-1:0] b_in,
    input  wire logic [W-1:0] sa_in,
    input  wire logic [W-1:0] sb_in,
    output stage_ctl_t        ctl_out,
    output logic      [W-1:0] a_out,
    output logic      [W-1:0] b_out,
    output logic      [W-1:0] sa_out,
    output logic      [W-1:0] sb_out
);

    localparam int DW = (W > 1) ? $clog2(W) : 1;

    function automatic logic [DW-1:0] deg_of(input logic [W-1:0] p);
        logic [DW-1:0] d;
        d = '0;
        for (int i = 0; i < W; i++) begin
            if (p[i]) begin
                d = DW'(i);
            end
        end
        return d;
    endfunction

    stage_ctl_t    ctl_reg;
    logic [W-1:0]  a_reg, b_reg, sa_reg, sb_reg;
    logic [W-1:0]  a_next, b_next, sa_next, sb_next;
    logic [W-1:0]  hi, lo, shi, slo;
    logic [DW-1:0] da, db, dh, dl, sh;
    logic          swap;

    always_comb
    begin
        da   = deg_of(a_in);
        db   = deg_of(b_in);
        // A zero on top always moves down so the nonzero one leads.
        swap = (a_in == '0) || ((b_in != '0) && (db > da));
        hi   = swap ? b_in  : a_in;
        lo   = swap ? a_in  : b_in;
        shi  = swap ? sb_in : sa_in;
        slo  = swap ? sa_in : sb_in;
        dh   = swap ? db : da;
        dl   = swap ? da : db;
        sh   = dh - dl;
        a_next  = hi;
        sa_next = shi;
        if (lo != '0) begin
            a_next  = hi ^ (lo << sh);
            sa_next = shi ^ (slo << sh);
        end
        b_next  = lo;
        sb_next = slo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        sa_reg <= sa_next;
        sb_reg <= sb_next;
    end

    assign ctl_out = ctl_reg;
    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign sa_out  = sa_reg;
    assign sb_out  = sb_reg;

endmodule
`default_nettype wire

@@ src/gf2_poly_inverse.sv @@
// ---------------------------------------------------------------------------
// gf2_poly_inverse
// Inverse of a binary polynomial modulo a programmable modulus by a pipeline
// of extended Euclid reduction steps.
// ---------------------------------------------------------------------------
//  channel   | signals                          | transfer when
//  input     | start, busy, operand             | start && !busy
//  result    | done, inverse_poly, no_inverse   | done (one cycle)
//  config    | cfg_valid, cfg_ready, modulus_poly | cfg_valid && cfg_ready
//
// An item may enter every cycle. The entry register loads at the transfer edge,
// the 2*DEGREE reduction stages follow, and the result register then raises done.
// Each stage lowers the degree sum by at least one while both polynomials are
// nonzero, which sets the 2*DEGREE stage count.
// busy stays low and the receiver cannot stall.
// Reset clears the valid bits and loads the modulus x^8+x^4+x^3+x+1.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module gf2_poly_inverse
    import gpi_pkg::*;
#(
    parameter int DEGREE = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [DEGREE-1:0] operand,
    output logic                   done,
    output logic      [DEGREE-1:0] inverse_poly,
    output logic                   no_inverse,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [DEGREE:0]   modulus_poly
);

    localparam int W       = DEGREE + 1;
    localparam int NSTEP   = 2 * DEGREE;
    localparam int LATENCY = NSTEP + 2;
    localparam logic [W-1:0] MOD_RESET = W'(283);

    logic [W-1:0] mod_reg;
    logic         accept;

    stage_ctl_t   ctl   [NSTEP+1];
    logic [W-1:0] a_s   [NSTEP+1];
    logic [W-1:0] b_s   [NSTEP+1];
    logic [W-1:0] sa_s  [NSTEP+1];
    logic [W-1:0] sb_s  [NSTEP+1];

    stage_ctl_t   ctl_reg;
    logic [W-1:0] a_reg, b_reg;
    logic         done_reg, fail_reg;
    logic [DEGREE-1:0] inv_reg;
    logic         fail_next;
    logic         gcd_in_a, gcd_in_b;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mod_reg <= MOD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            mod_reg <= modulus_poly;
        end
    end

    // Entry stage: a modulus of zero or one never yields an inverse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg.valid <= accept;
            ctl_reg.fail  <= (mod_reg[W-1:1] == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= mod_reg;
        b_reg <= {1'b0, operand};
    end

    assign ctl[0]  = ctl_reg;
    assign a_s[0]  = a_reg;
    assign b_s[0]  = b_reg;
    assign sa_s[0] = '0;
    assign sb_s[0] = W'(1);

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        gpi_step #(.W(W)) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl[k]),
            .a_in    (a_s[k]),
            .b_in    (b_s[k]),
            .sa_in   (sa_s[k]),
            .sb_in   (sb_s[k]),
            .ctl_out (ctl[k+1]),
            .a_out   (a_s[k+1]),
            .b_out   (b_s[k+1]),
            .sa_out  (sa_s[k+1]),
            .sb_out  (sb_s[k+1])
        );
    end

    // The last step may leave the gcd in either slot with zero in the other.
    assign gcd_in_a  = (a_s[NSTEP] == W'(1)) && (b_s[NSTEP] == '0);
    assign gcd_in_b  = (a_s[NSTEP] == '0) && (b_s[NSTEP] == W'(1));
    assign fail_next = ctl[NSTEP].fail || !(gcd_in_a || gcd_in_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= ctl[NSTEP].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        fail_reg <= fail_next;
        if (fail_next) begin
            inv_reg <= '0;
        end else if (gcd_in_a) begin
            inv_reg <= sa_s[NSTEP][DEGREE-1:0];
        end else begin
            inv_reg <= sb_s[NSTEP][DEGREE-1:0];
        end
    end

    assign done         = done_reg;
    assign no_inverse   = fail_reg;
    assign inverse_poly = inv_reg;

    `ASSERT_DELAY(a_latency, clk, rst_n, start && !busy, LATENCY, done)
    `ASSERT_IMPL(a_fail_zero, clk, rst_n, done && no_inverse, inverse_poly == '0)

endmodule
`default_nettype wire
